/* sv/mtp_pkg.sv */
// Shared types, constants and tables for the meter telegram parser.
package mtp_pkg;

  localparam int NUM_CODES  = 24;
  localparam int CODE_SLOTS = 24;
  localparam int ACT_CODES  = (NUM_CODES < CODE_SLOTS) ? NUM_CODES : CODE_SLOTS;
  localparam int IDX_W      = 5;
  localparam int VAL_W      = 48;
  localparam int CRC_W      = 16;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [VAL_W-1:0] VAL_MAX   = {VAL_W{1'b1}};
  localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY  = 16'hA001;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIGIT,
    OP_DOT,
    OP_BAD,
    OP_LPAR,
    OP_EOL,
    OP_RESET
  } op_t;

  // Front-to-back queue entry: one classified beat.
  typedef struct packed {
    op_t                   op;
    logic [3:0]            digit;
    logic                  term_hit;   // byte equals terminator of lowest complete code
    logic                  has_match;
    logic [IDX_W-1:0]      idx;
    logic                  frame_end;
    logic [CRC_W-1:0]      crc;
    logic [CRC_W-1:0]      hexval;
  } cmd_t;

  function automatic logic [3:0] code_len(input int k);
    case (k)
      4, 6, 7, 23: return 4'd11;
      5, 8, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22: return 4'd10;
      0, 1, 2, 3, 9, 10: return 4'd9;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] code_char(input int k, input logic [3:0] col);
    logic [87:0] s;
    logic [3:0]  len;
    logic [7:0]  c;
    len = code_len(k);
    case (k)
      0: s = 88'("1-0:1.8.1");    1: s = 88'("1-0:1.8.2");
      2: s = 88'("1-0:2.8.1");    3: s = 88'("1-0:2.8.2");
      4: s = 88'("0-0:96.7.21");  5: s = 88'("0-0:96.7.9");
      6: s = 88'("1-0:32.32.0");  7: s = 88'("1-0:32.36.0");
      8: s = 88'("0-1:24.2.1");   9: s = 88'("1-0:1.7.0");
      10: s = 88'("1-0:2.7.0");   11: s = 88'("1-0:21.7.0");
      12: s = 88'("1-0:41.7.0");  13: s = 88'("1-0:61.7.0");
      14: s = 88'("1-0:22.7.0");  15: s = 88'("1-0:42.7.0");
      16: s = 88'("1-0:62.7.0");  17: s = 88'("1-0:31.7.0");
      18: s = 88'("1-0:51.7.0");  19: s = 88'("1-0:71.7.0");
      20: s = 88'("1-0:32.7.0");  21: s = 88'("1-0:52.7.0");
      22: s = 88'("1-0:72.7.0");  23: s = 88'("0-0:96.14.0");
      default: s = '0;
    endcase
    // text is right-aligned: first character sits in the highest used byte
    c = (col < len) ? s[8*(int'(len) - 1 - int'(col)) +: 8] : 8'h00;
    return c;
  endfunction

  function automatic logic [7:0] code_term(input logic [IDX_W-1:0] k);
    case (k)
      5'd4, 5'd5, 5'd6, 5'd7, 5'd23: return CH_RPAR;
      default: return CH_STAR;
    endcase
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* sv/mtp_front.sv */
// Front end: frame tracking, CRC, code matching and byte classification.
module mtp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_byte,
  input  logic           in_take,
  output mtp_pkg::cmd_t  cmd,
  output logic           cmd_valid
);
  import mtp_pkg::*;

  logic                 in_frame_r, in_frame_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic [3:0]           col_r, col_nxt;
  logic [ACT_CODES-1:0] cand_r, cand_nxt;
  logic [ACT_CODES-1:0] comp_r, comp_nxt;
  logic                 cap_r, cap_nxt;
  logic [1:0]           hcnt_r, hcnt_nxt;
  logic                 hstop_r, hstop_nxt;
  logic [15:0]          hval_r, hval_nxt;

  logic [15:0]          crc_fed;
  logic [4:0]           hex_d;
  logic                 found;
  logic [IDX_W-1:0]     low_idx;

  always_comb begin
    hex_d = 5'h10;
    if (in_byte inside {[8'h30:8'h39]}) hex_d = {1'b0, in_byte[3:0]};
    else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) hex_d = {1'b0, in_byte[3:0] + 4'd9};
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    crc_nxt      = crc_r;
    col_nxt      = col_r;
    cand_nxt     = cand_r;
    comp_nxt     = comp_r;
    cap_nxt      = cap_r;
    hcnt_nxt     = hcnt_r;
    hstop_nxt    = hstop_r;
    hval_nxt     = hval_r;
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd_valid    = 1'b0;
    found        = 1'b0;
    low_idx      = '0;
    crc_fed      = crc_byte((in_byte == CH_SLASH) ? CRC_INIT : crc_r, in_byte);
    if (cap_r) begin
      if (!hstop_r) begin
        if (hex_d[4]) hstop_nxt = 1'b1;
        else hval_nxt = {hval_r[11:0], hex_d[3:0]};
      end
      hcnt_nxt = hcnt_r + 2'd1;
      if (hcnt_r == 2'd3) begin
        cmd.frame_end = 1'b1;
        cmd.crc       = crc_r;
        cmd.hexval    = hval_nxt;
        cmd_valid     = 1'b1;
        cap_nxt       = 1'b0;
        in_frame_nxt  = 1'b0;
        crc_nxt       = CRC_INIT;
        col_nxt       = '0;
        cand_nxt      = '1;
        comp_nxt      = '0;
      end
    end else if (in_byte == CH_SLASH || in_frame_r) begin
      in_frame_nxt = 1'b1;
      crc_nxt      = crc_fed;
      cmd_valid    = 1'b1;
      if (in_byte == CH_SLASH) begin
        col_nxt  = '0;
        cand_nxt = '1;
        comp_nxt = '0;
      end else begin
        col_nxt  = col_r;
        cand_nxt = cand_r;
        comp_nxt = comp_r;
      end
      if (in_byte == CH_BANG) begin
        cmd.op    = OP_RESET;
        col_nxt   = '0;
        cand_nxt  = '1;
        comp_nxt  = '0;
        cap_nxt   = 1'b1;
        hcnt_nxt  = '0;
        hstop_nxt = 1'b0;
        hval_nxt  = '0;
      end else if (in_byte == CH_CR || in_byte == CH_LF) begin
        for (int k = ACT_CODES - 1; k >= 0; k--) begin
          if (comp_nxt[k]) begin
            found   = 1'b1;
            low_idx = IDX_W'(k);
          end
        end
        cmd.op        = OP_EOL;
        cmd.has_match = found;
        cmd.idx       = low_idx;
        col_nxt       = '0;
        cand_nxt      = '1;
        comp_nxt      = '0;
      end else begin
        for (int k = 0; k < ACT_CODES; k++) begin
          if (cand_nxt[k] && col_nxt < code_len(k)) begin
            if (in_byte != code_char(k, col_nxt)) cand_nxt[k] = 1'b0;
            else if (col_nxt + 4'd1 == code_len(k)) comp_nxt[k] = 1'b1;
          end
        end
        if (col_nxt != 4'd15) col_nxt = col_nxt + 4'd1;
        for (int k = ACT_CODES - 1; k >= 0; k--) begin
          if (comp_nxt[k]) begin
            found   = 1'b1;
            low_idx = IDX_W'(k);
          end
        end
        cmd.term_hit = found && (in_byte == code_term(low_idx));
        cmd.digit    = in_byte[3:0];
        if (in_byte == CH_SLASH) cmd.op = OP_RESET;
        else if (in_byte == CH_LPAR) cmd.op = OP_LPAR;
        else if (in_byte inside {[8'h30:8'h39]}) cmd.op = OP_DIGIT;
        else if (in_byte == CH_DOT) cmd.op = OP_DOT;
        else cmd.op = OP_BAD;
      end
    end
    cmd_valid = cmd_valid & in_take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      crc_r      <= CRC_INIT;
      col_r      <= '0;
      cand_r     <= '1;
      comp_r     <= '0;
      cap_r      <= 1'b0;
      hcnt_r     <= '0;
      hstop_r    <= 1'b0;
      hval_r     <= '0;
    end else if (in_take) begin
      in_frame_r <= in_frame_nxt;
      crc_r      <= crc_nxt;
      col_r      <= col_nxt;
      cand_r     <= cand_nxt;
      comp_r     <= comp_nxt;
      cap_r      <= cap_nxt;
      hcnt_r     <= hcnt_nxt;
      hstop_r    <= hstop_nxt;
      hval_r     <= hval_nxt;
    end
  end

endmodule

/* sv/mtp_queue.sv */
// Small FIFO of classified beats between front and back end.
module mtp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  mtp_pkg::cmd_t  wr_data,
  output logic           full,
  input  logic           rd_en,
  output mtp_pkg::cmd_t  rd_data,
  output logic           empty
);
  import mtp_pkg::*;

  cmd_t             mem [Q_DEPTH];
  logic [Q_AW:0]    wp_r, rp_r;

  assign empty   = (wp_r == rp_r);
  assign full    = (wp_r[Q_AW] != rp_r[Q_AW]) && (wp_r[Q_AW-1:0] == rp_r[Q_AW-1:0]);
  assign rd_data = mem[rp_r[Q_AW-1:0]];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r[Q_AW-1:0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + (Q_AW+1)'(1);
      if (rd_en) rp_r <= rp_r + (Q_AW+1)'(1);
    end
  end

endmodule

/* sv/mtp_back.sv */
// Back end: field accumulation, value latching and result register.
module mtp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mtp_pkg::cmd_t              cmd,
  input  logic                       cmd_avail,
  output logic                       cmd_take,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_result_kind,
  output logic [mtp_pkg::IDX_W-1:0]  out_item_index,
  output logic [mtp_pkg::VAL_W-1:0]  out_value_milli,
  output logic [15:0]                out_crc_computed,
  output logic [15:0]                out_crc_received,
  output logic                       out_crc_match
);
  import mtp_pkg::*;

  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             dot_r, dot_nxt, stop_r, stop_nxt, bad_r, bad_nxt;
  logic [1:0]       frac_r, frac_nxt;
  logic [VAL_W-1:0] lat_r, lat_nxt;
  logic             ov_r;
  logic             emit;
  logic [VAL_W+4:0] mul10, addend, sum;
  logic             ok;

  assign cmd_take = cmd_avail && (!ov_r || !out_stall);
  assign out_valid = ov_r;

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    dot_nxt  = dot_r;
    stop_nxt = stop_r;
    bad_nxt  = bad_r;
    frac_nxt = frac_r;
    lat_nxt  = lat_r;
    emit     = 1'b0;
    mul10    = '0;
    addend   = '0;
    sum      = '0;
    ok       = !bad_r && cnt_r != 5'd0 && cnt_r <= 5'd15;
    if (cmd.frame_end) begin
      emit = 1'b1;
    end else begin
      case (cmd.op)
        OP_RESET, OP_EOL: begin
          emit     = (cmd.op == OP_EOL) && cmd.has_match;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          dot_nxt  = 1'b0;
          stop_nxt = 1'b0;
          bad_nxt  = 1'b1;
          frac_nxt = '0;
          lat_nxt  = '0;
        end
        OP_LPAR: begin
          acc_nxt  = '0;
          cnt_nxt  = '0;
          dot_nxt  = 1'b0;
          stop_nxt = 1'b0;
          bad_nxt  = 1'b0;
          frac_nxt = '0;
          lat_nxt  = '0;
        end
        OP_DIGIT, OP_DOT, OP_BAD: begin
          if (cmd.term_hit) lat_nxt = ok ? acc_r : '0;
          if (cnt_r != 5'd31) cnt_nxt = cnt_r + 5'd1;
          if (cmd.op == OP_DIGIT) begin
            if (!stop_r) begin
              if (!dot_r) begin
                mul10  = {2'b00, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
                addend = (VAL_W+5)'(cmd.digit) * (VAL_W+5)'(1000);
                sum    = mul10 + addend;
                acc_nxt = (sum > {5'b0, VAL_MAX}) ? VAL_MAX : sum[VAL_W-1:0];
              end else if (frac_r != 2'd3) begin
                case (frac_r)
                  2'd0:    addend = (VAL_W+5)'(cmd.digit) * (VAL_W+5)'(100);
                  2'd1:    addend = (VAL_W+5)'(cmd.digit) * (VAL_W+5)'(10);
                  default: addend = (VAL_W+5)'(cmd.digit);
                endcase
                sum      = {5'b0, acc_r} + addend;
                acc_nxt  = (sum > {5'b0, VAL_MAX}) ? VAL_MAX : sum[VAL_W-1:0];
                frac_nxt = frac_r + 2'd1;
              end
            end
          end else if (cmd.op == OP_DOT) begin
            if (dot_r) stop_nxt = 1'b1;
            else dot_nxt = 1'b1;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      dot_r  <= 1'b0;
      stop_r <= 1'b0;
      bad_r  <= 1'b1;
      frac_r <= '0;
      lat_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cmd_take && emit) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (cmd_take) begin
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        dot_r  <= dot_nxt;
        stop_r <= stop_nxt;
        bad_r  <= bad_nxt;
        frac_r <= frac_nxt;
        lat_r  <= lat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && emit) begin
      out_result_kind  <= cmd.frame_end;
      out_item_index   <= cmd.frame_end ? '0 : cmd.idx;
      out_value_milli  <= cmd.frame_end ? '0 : lat_r;
      out_crc_computed <= cmd.frame_end ? cmd.crc : '0;
      out_crc_received <= cmd.frame_end ? cmd.hexval : '0;
      out_crc_match    <= cmd.frame_end && (cmd.crc == cmd.hexval);
    end
  end

endmodule

/* sv/meter_telegram_parser.sv */
// Top level of the meter telegram parser.
//   channel | ports                 | direction
//   input   | in_valid/in_stall     | bytes in, in_rx_byte
//   result  | out_valid/out_stall   | line values and frame CRC results
// One byte per cycle unless the queue is full; front classifies and updates CRC/matcher.
// Back end folds one beat per cycle into the field accumulator while no result is stalled;
// a 4-deep queue decouples them; out_valid is registered when back end takes a closing beat.
// in_stall rises only when the queue is full; reset is synchronous, active low.
module meter_telegram_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_result_kind,
  output logic [mtp_pkg::IDX_W-1:0]  out_item_index,
  output logic [mtp_pkg::VAL_W-1:0]  out_value_milli,
  output logic [15:0]                out_crc_computed,
  output logic [15:0]                out_crc_received,
  output logic                       out_crc_match
);
  import mtp_pkg::*;

  cmd_t  f_cmd, q_cmd;
  logic  f_valid, q_full, q_empty, b_take, in_take;

  assign in_stall = q_full;
  assign in_take  = in_valid && !q_full;

  mtp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_rx_byte),
    .in_take   (in_take),
    .cmd       (f_cmd),
    .cmd_valid (f_valid)
  );

  mtp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_valid),
    .wr_data (f_cmd),
    .full    (q_full),
    .rd_en   (b_take),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  mtp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (q_cmd),
    .cmd_avail        (!q_empty),
    .cmd_take         (b_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_item_index   (out_item_index),
    .out_value_milli  (out_value_milli),
    .out_crc_computed (out_crc_computed),
    .out_crc_received (out_crc_received),
    .out_crc_match    (out_crc_match)
  );

endmodule
